// ===== rtl/npcm_pkg.sv =====
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and constants for the nearest palette colour mapper.
// ----------------------------------------------------------------------------
package npcm_pkg;

    // field widths
    localparam int unsigned FUNC_W  = 1;
    localparam int unsigned EIDX_W  = 7;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned DIST_W  = 10;
    localparam int unsigned COLOR_W = 3 * CHAN_W;
    localparam int unsigned SIZE_W  = 8;

    // APB geometry: one 32-bit register, word aligned
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // register indexes
    localparam logic [APB_ADDR_W-3:0] REG_PALETTE_SIZE = 1'b0;

    // reset value of palette_size
    localparam logic [SIZE_W-1:0] PALETTE_SIZE_RST = 8'd1;

    // input word operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 1'b0,
        FUNC_MAP   = 1'b1
    } t_func;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

endpackage

// ===== rtl/npcm_req_if.sv =====
// ----------------------------------------------------------------------------
// npcm_req_if
// Input channel: palette write or pixel map word.
// ----------------------------------------------------------------------------
interface npcm_req_if;
    logic                            valid;
    logic                            ready;
    logic [npcm_pkg::FUNC_W-1:0]     func;
    logic [npcm_pkg::EIDX_W-1:0]     entry_index;
    logic [npcm_pkg::CHAN_W-1:0]     red;
    logic [npcm_pkg::CHAN_W-1:0]     green;
    logic [npcm_pkg::CHAN_W-1:0]     blue;

    modport source (output valid, func, entry_index, red, green, blue, input ready);
    modport sink   (input valid, func, entry_index, red, green, blue, output ready);
endinterface

// ===== rtl/npcm_res_if.sv =====
// ----------------------------------------------------------------------------
// npcm_res_if
// Output channel: nearest palette entry for one pixel.
// ----------------------------------------------------------------------------
interface npcm_res_if;
    logic                            valid;
    logic                            ready;
    logic [npcm_pkg::EIDX_W-1:0]     palette_index;
    logic [npcm_pkg::CHAN_W-1:0]     out_red;
    logic [npcm_pkg::CHAN_W-1:0]     out_green;
    logic [npcm_pkg::CHAN_W-1:0]     out_blue;
    logic [npcm_pkg::DIST_W-1:0]     distance;

    modport source (output valid, palette_index, out_red, out_green, out_blue, distance,
                    input ready);
    modport sink   (input valid, palette_index, out_red, out_green, out_blue, distance,
                    output ready);
endinterface

// ===== rtl/npcm_ram.sv =====
// ----------------------------------------------------------------------------
// npcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npcm_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/nearest_palette_color_mapper_core.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper_core
// Maps pixels onto a stored palette by smallest L1 colour distance.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake        word
//  i_req     in    valid/ready      func, entry_index, red, green, blue
//  o_res     out   valid/ready      palette_index, out_red/green/blue, distance
//  apb       in    psel/penable     palette_size at byte address 0
//
//  A write word writes the palette RAM directly.
//  A map word scans N entries (N = palette_size, held to 1..PALETTE_DEPTH):
//  one RAM read per cycle on the single read port, then a drain state to
//  compare the last entry and a result state to load the result register.
//  Reset clears control state and sets palette_size to 1; the palette RAM is
//  not cleared. A stalled result is held in the output register while the
//  next word is taken; a further map result waits for that register.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper_core #(
    parameter int unsigned PALETTE_DEPTH = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    npcm_req_if.sink                              i_req,
    npcm_res_if.source                            o_res,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [npcm_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [npcm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [npcm_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [npcm_pkg::SIZE_W-1:0] r_palette_size;
    logic                        cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[npcm_pkg::APB_ADDR_W-1:2] == npcm_pkg::REG_PALETTE_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_size <= npcm_pkg::PALETTE_SIZE_RST;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_palette_size <= pwdata[npcm_pkg::SIZE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_hit) begin
            prdata = {{(npcm_pkg::APB_DATA_W - npcm_pkg::SIZE_W){1'b0}}, r_palette_size};
        end
    end

    // ------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------
    npcm_pkg::t_state r_state, n_state;

    logic [IDX_W-1:0]               r_addr;
    logic [IDX_W-1:0]               r_last_idx;
    logic                           r_rd_vld;
    logic [IDX_W-1:0]               r_rd_idx;
    logic [npcm_pkg::CHAN_W-1:0]    r_px_r, r_px_g, r_px_b;

    logic [IDX_W-1:0]               r_best_idx;
    logic [npcm_pkg::DIST_W-1:0]    r_best_dist;
    logic [npcm_pkg::COLOR_W-1:0]   r_best_color;

    logic                           r_out_vld;
    logic [npcm_pkg::EIDX_W-1:0]    r_out_idx;
    logic [npcm_pkg::COLOR_W-1:0]   r_out_color;
    logic [npcm_pkg::DIST_W-1:0]    r_out_dist;

    logic                           req_fire;
    logic                           is_map;
    logic                           out_free;
    logic                           scan_end;
    logic                           ram_we;
    logic                           ram_re;
    logic [IDX_W-1:0]               ram_waddr;
    logic [npcm_pkg::COLOR_W-1:0]   ram_rdata;
    logic [npcm_pkg::EIDX_W:0]      eidx_ext;
    logic [8:0]                     scan_cnt;
    logic [8:0]                     scan_last;
    logic [npcm_pkg::DIST_W-1:0]    cur_dist;
    logic [7:0]                     best_ext;

    // ------------------------------------------------------------------
    // handshake and decode
    // ------------------------------------------------------------------
    assign req_fire = i_req.valid && i_req.ready;
    assign is_map   = (npcm_pkg::t_func'(i_req.func) == npcm_pkg::FUNC_MAP);
    assign out_free = !r_out_vld || o_res.ready;
    assign scan_end = (r_addr == r_last_idx);

    // write address; out-of-range writes are dropped
    assign eidx_ext  = {1'b0, i_req.entry_index};
    assign ram_waddr = eidx_ext[IDX_W-1:0];

    // entries scanned: palette_size held to 1..PALETTE_DEPTH
    always_comb begin
        scan_cnt = {1'b0, r_palette_size};
        if (scan_cnt == 9'd0) begin
            scan_cnt = 9'd1;
        end else if (scan_cnt > 9'(PALETTE_DEPTH)) begin
            scan_cnt = 9'(PALETTE_DEPTH);
        end
        scan_last = scan_cnt - 9'd1;
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            npcm_pkg::ST_IDLE: begin
                if (req_fire && is_map) begin
                    n_state = npcm_pkg::ST_SCAN;
                end
            end
            npcm_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = npcm_pkg::ST_DRAIN;
                end
            end
            npcm_pkg::ST_DRAIN: begin
                n_state = npcm_pkg::ST_RESULT;
            end
            npcm_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_state = npcm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = npcm_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // state outputs
    // ------------------------------------------------------------------
    always_comb begin
        i_req.ready = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        case (r_state)
            npcm_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                ram_we      = req_fire && !is_map &&
                              ({1'b0, eidx_ext} < 9'(PALETTE_DEPTH));
            end
            npcm_pkg::ST_SCAN: begin
                ram_re = 1'b1;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npcm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // palette RAM
    // ------------------------------------------------------------------
    npcm_ram #(
        .WIDTH (npcm_pkg::COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_req.red, i_req.green, i_req.blue}),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // scan address and read tracking
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= ram_re;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (r_state == npcm_pkg::ST_IDLE && req_fire && is_map) begin
            r_addr     <= '0;
            r_last_idx <= scan_last[IDX_W-1:0];
            r_px_r     <= i_req.red;
            r_px_g     <= i_req.green;
            r_px_b     <= i_req.blue;
        end else if (r_state == npcm_pkg::ST_SCAN && !scan_end) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // L1 distance of the returned entry and running minimum
    // ------------------------------------------------------------------
    function automatic logic [npcm_pkg::CHAN_W-1:0] abs_diff(
        input logic [npcm_pkg::CHAN_W-1:0] a,
        input logic [npcm_pkg::CHAN_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign cur_dist =
        npcm_pkg::DIST_W'(abs_diff(ram_rdata[23:16], r_px_r)) +
        npcm_pkg::DIST_W'(abs_diff(ram_rdata[15:8],  r_px_g)) +
        npcm_pkg::DIST_W'(abs_diff(ram_rdata[7:0],   r_px_b));

    // first entry always taken; later ones only if strictly nearer
    always_ff @(posedge i_clk) begin
        if (r_rd_vld && (r_rd_idx == '0 || cur_dist < r_best_dist)) begin
            r_best_idx   <= r_rd_idx;
            r_best_dist  <= cur_dist;
            r_best_color <= ram_rdata;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    assign best_ext = 8'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == npcm_pkg::ST_RESULT && out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == npcm_pkg::ST_RESULT && out_free) begin
            r_out_idx   <= best_ext[npcm_pkg::EIDX_W-1:0];
            r_out_color <= r_best_color;
            r_out_dist  <= r_best_dist;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.palette_index = r_out_idx;
    assign o_res.out_red       = r_out_color[23:16];
    assign o_res.out_green     = r_out_color[15:8];
    assign o_res.out_blue      = r_out_color[7:0];
    assign o_res.distance      = r_out_dist;

endmodule

// ===== verif/nearest_palette_color_mapper_core_test.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper_core_test
// Self-checking bench for the palette mapper. A queue-fed driver offers palette
// write and pixel map words, a monitor predicts the nearest entry for every
// accepted map word and checks each result word in order. palette_size is
// changed over APB between phases, only once the block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_palette_color_mapper_core_test;

    localparam int unsigned PALETTE_DEPTH = 128;
    localparam int unsigned DIST_START    = 32'h100_0000;
    localparam int unsigned CYCLE_LIMIT   = 1_200_000;
    localparam int unsigned WRITE_SETTLE  = 8;
    localparam int unsigned LONG_HOLD     = 400;
    localparam logic [npcm_pkg::APB_ADDR_W-1:0] SIZE_ADDR =
        {npcm_pkg::REG_PALETTE_SIZE, 2'b00};

    typedef struct packed {
        npcm_pkg::t_func                 func;
        logic [npcm_pkg::EIDX_W-1:0]     entry;
        logic [npcm_pkg::COLOR_W-1:0]    rgb;
    } t_word;

    typedef struct packed {
        logic [npcm_pkg::EIDX_W-1:0]     idx;
        logic [npcm_pkg::COLOR_W-1:0]    rgb;
        logic [npcm_pkg::DIST_W-1:0]     distance;
    } t_match;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [npcm_pkg::APB_ADDR_W-1:0] paddr;
    logic [npcm_pkg::APB_DATA_W-1:0] pwdata, prdata;

    npcm_req_if req_bus ();
    npcm_res_if res_bus ();

    nearest_palette_color_mapper_core #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // pending input words, expected nearest matches
    t_word  word_q[$];
    t_match match_q[$];

    // predictor state: palette copy and register copy
    logic [npcm_pkg::COLOR_W-1:0] palette_rgb [PALETTE_DEPTH];
    logic [npcm_pkg::SIZE_W-1:0]  size_reg;

    // stimulus plan: what the words queued so far will have written
    logic [npcm_pkg::COLOR_W-1:0] plan_rgb [PALETTE_DEPTH];
    bit                           plan_written [PALETTE_DEPTH];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        long_hold = 1'b0;
    event        long_hold_ev;
    logic        req_taken;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // entries a lookup scans for a given register value
    function automatic int unsigned scan_count(input logic [npcm_pkg::SIZE_W-1:0] sz);
        if (sz == 0)
            return 1;
        if (sz > PALETTE_DEPTH)
            return PALETTE_DEPTH;
        return sz;
    endfunction

    function automatic int unsigned abs_diff(input logic [npcm_pkg::CHAN_W-1:0] a, b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int unsigned l1_dist(input logic [npcm_pkg::COLOR_W-1:0] c, p);
        return abs_diff(c[23:16], p[23:16]) + abs_diff(c[15:8], p[15:8]) +
               abs_diff(c[7:0], p[7:0]);
    endfunction

    // nearest entry by L1 distance; strict compare keeps the lowest index on ties
    function automatic t_match nearest_entry(input logic [npcm_pkg::COLOR_W-1:0] pix);
        t_match      m;
        int unsigned n;
        int unsigned d;
        int unsigned best_d;
        int unsigned best_i;
        n      = scan_count(size_reg);
        best_d = DIST_START;
        best_i = 0;
        for (int unsigned i = 0; i < n; i++) begin
            d = l1_dist(palette_rgb[i], pix);
            if (d < best_d) begin
                best_d = d;
                best_i = i;
            end
        end
        m.idx      = best_i[npcm_pkg::EIDX_W-1:0];
        m.rgb      = palette_rgb[best_i];
        m.distance = best_d[npcm_pkg::DIST_W-1:0];
        return m;
    endfunction

    // ---- stimulus helpers ----
    function automatic void queue_write(input int unsigned idx,
                                        input logic [npcm_pkg::COLOR_W-1:0] c);
        t_word w;
        w.func  = npcm_pkg::FUNC_WRITE;
        w.entry = idx[npcm_pkg::EIDX_W-1:0];
        w.rgb   = c;
        word_q.push_back(w);
        plan_rgb[idx]     = c;
        plan_written[idx] = 1'b1;
    endfunction

    function automatic void queue_map(input logic [npcm_pkg::COLOR_W-1:0] c);
        t_word w;
        w.func  = npcm_pkg::FUNC_MAP;
        w.entry = npcm_pkg::EIDX_W'($urandom_range(127));
        w.rgb   = c;
        word_q.push_back(w);
    endfunction

    function automatic logic [npcm_pkg::CHAN_W-1:0] extreme_chan();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return npcm_pkg::CHAN_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [npcm_pkg::COLOR_W-1:0] extreme_colour();
        return {extreme_chan(), extreme_chan(), extreme_chan()};
    endfunction

    // a colour a few steps from c, held to the channel range
    function automatic logic [npcm_pkg::COLOR_W-1:0] near_colour(
        input logic [npcm_pkg::COLOR_W-1:0] c
    );
        logic [npcm_pkg::COLOR_W-1:0] o;
        int                           v;
        for (int k = 0; k < 3; k++) begin
            v = int'(c[8*k +: 8]) + int'($urandom_range(6)) - 3;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            o[8*k +: 8] = v[7:0];
        end
        return o;
    endfunction

    // ---- driver: offers queued words, holds a word until taken ----
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (!req_bus.valid || req_taken) begin
            if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t_word w;
                w = word_q.pop_front();
                req_bus.valid       <= 1'b1;
                req_bus.func        <= w.func;
                req_bus.entry_index <= w.entry;
                req_bus.red         <= w.rgb[23:16];
                req_bus.green       <= w.rgb[15:8];
                req_bus.blue        <= w.rgb[7:0];
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n)
            res_bus.ready <= 1'b0;
        else
            res_bus.ready <= !long_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver hold-off, counted here while the sender keeps going
    initial begin
        @(long_hold_ev);
        long_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // ---- monitor: predict on accepted words, check result words ----
    always @(posedge i_clk) begin
        t_match want;
        t_match got;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_bus.valid && req_bus.ready;
            if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
                if (req_bus.func == npcm_pkg::FUNC_WRITE)
                    palette_rgb[req_bus.entry_index] =
                        {req_bus.red, req_bus.green, req_bus.blue};
                else
                    match_q.push_back(nearest_entry({req_bus.red, req_bus.green,
                                                     req_bus.blue}));
            end
            if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
                got = {res_bus.palette_index, res_bus.out_red, res_bus.out_green,
                       res_bus.out_blue, res_bus.distance};
                if (match_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word idx=%0d rgb=%06h dist=%0d",
                                 got.idx, got.rgb, got.distance);
                end else begin
                    want = match_q.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result mismatch: exp idx=%0d rgb=%06h dist=%0d, ",
                                      "got idx=%0d rgb=%06h dist=%0d"},
                                     want.idx, want.rgb, want.distance,
                                     got.idx, got.rgb, got.distance);
                    end
                end
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---- sequencing ----
    task automatic drain_all();
        while (word_q.size() != 0 || req_bus.valid === 1'b1 || match_q.size() != 0)
            @(posedge i_clk);
        repeat (WRITE_SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [npcm_pkg::APB_DATA_W-1:0] wdata,
                            output logic [npcm_pkg::APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = SIZE_ADDR;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1)
            @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // drain, write palette_size (junk in the upper bits), read it back
    task automatic set_palette_size(input logic [npcm_pkg::SIZE_W-1:0] sz);
        logic [npcm_pkg::APB_DATA_W-1:0] rd;
        drain_all();
        apb_xfer(1'b1, ($urandom() & 32'hFFFF_FF00) | sz, rd);
        size_reg = sz;
        apb_xfer(1'b0, $urandom(), rd);
        if (rd[npcm_pkg::SIZE_W-1:0] !== sz) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("palette_size readback: exp %0d, got %0d", sz,
                         rd[npcm_pkg::SIZE_W-1:0]);
        end
    endtask

    task automatic set_idling(input int unsigned phase, input int unsigned n_phases);
        case ((phase * 3) / n_phases)
            0:       begin send_idle_pct = 31; recv_idle_pct = 78; end
            1:       begin send_idle_pct = 78; recv_idle_pct = 31; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
    endtask

    initial begin
        int unsigned sizes [21] = '{2, 5, 1, 8, 16, 3, 33, 4, 128, 2, 255, 7, 1, 64, 0,
                                    12, 129, 6, 200, 3, 24};
        int unsigned items [21] = '{100, 90, 80, 90, 80, 90, 60, 90, 30, 100, 25, 90, 70,
                                    35, 60, 80, 20, 90, 20, 90, 60};
        int unsigned n_phases;
        int unsigned cnt;
        int unsigned sel;
        int unsigned idx;
        logic [npcm_pkg::COLOR_W-1:0] c;

        n_phases = 3 + 21;
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        req_bus.valid       = 1'b0;
        req_bus.func        = npcm_pkg::FUNC_WRITE;
        req_bus.entry_index = '0;
        req_bus.red         = '0;
        req_bus.green       = '0;
        req_bus.blue        = '0;
        res_bus.ready       = 1'b0;
        size_reg            = npcm_pkg::PALETTE_SIZE_RST;
        for (int i = 0; i < PALETTE_DEPTH; i++) begin
            palette_rgb[i]  = '0;
            plan_rgb[i]     = '0;
            plan_written[i] = 1'b0;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset size of one, channel extremes, top entry index
        set_idling(0, n_phases);
        queue_write(0, 24'h000000);
        queue_map(24'hFFFFFF);
        queue_map(24'h000000);
        queue_write(0, 24'hFFFFFF);
        queue_map(24'h000000);
        queue_map(24'hFF0080);
        queue_write(127, 24'h00FF00);

        // size zero still scans entry 0
        set_palette_size(8'd0);
        set_idling(1, n_phases);
        queue_map(24'h0C2238);
        queue_write(1, 24'h010203);
        queue_map(24'h010203);

        // ties: identical entries, and equal distance to different colours
        set_palette_size(8'd3);
        set_idling(2, n_phases);
        queue_write(2, 24'h010203);
        queue_map(24'h010203);
        queue_map(24'h000000);
        queue_write(0, 24'h030203);
        queue_map(24'h020203);
        queue_write(2, 24'h000000);
        queue_map(24'h000001);
        queue_map(24'h808080);

        // random phases over a range of sizes, saturating ones among them
        for (int p = 0; p < 21; p++) begin
            set_palette_size(npcm_pkg::SIZE_W'(sizes[p]));
            set_idling(p + 3, n_phases);
            cnt = scan_count(npcm_pkg::SIZE_W'(sizes[p]));
            // every scanned entry must hold a colour before the first lookup
            for (int i = 0; i < cnt; i++)
                if (!plan_written[i])
                    queue_write(i, npcm_pkg::COLOR_W'($urandom_range(24'hFFFFFF)));
            for (int k = 0; k < items[p]; k++) begin
                sel = $urandom_range(99);
                if (sel < 35) begin
                    idx = ($urandom_range(99) < 60) ? $urandom_range(cnt - 1)
                                                     : $urandom_range(127);
                    sel = $urandom_range(99);
                    if (sel < 20)
                        c = plan_rgb[$urandom_range(cnt - 1)];
                    else if (sel < 35)
                        c = extreme_colour();
                    else
                        c = npcm_pkg::COLOR_W'($urandom_range(24'hFFFFFF));
                    queue_write(idx, c);
                end else begin
                    sel = $urandom_range(99);
                    if (sel < 40)
                        c = near_colour(plan_rgb[$urandom_range(cnt - 1)]);
                    else if (sel < 60)
                        c = extreme_colour();
                    else
                        c = npcm_pkg::COLOR_W'($urandom_range(24'hFFFFFF));
                    queue_map(c);
                end
            end
            if (p == 9)
                ->long_hold_ev;
        end

        drain_all();
        repeat (PALETTE_DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0 && match_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
